// File: hdl/ptdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the prime trial-division tester.
// Depends on nothing; ptdt_cell, ptdt_chain, the top level and the testbench import it.
package ptdt_pkg;

   // Width of one prime table entry.
   localparam int TABLE_BITS = 32;

   // Number of primes present in the table after reset.
   localparam int SEED_COUNT = 5;

   // Command codes carried in the request tuser bit.
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_TEST   = 1'b1;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // What one divider cell hands to the next one.
   typedef struct packed {
      logic                  valid;
      logic [TABLE_BITS-1:0] divisor;
      logic [TABLE_BITS-1:0] rem;
   } lane_type;

   // Primes that the table holds from reset, by index.
   function automatic logic [TABLE_BITS-1:0] seed_prime(input logic [2:0] idx);
      logic [TABLE_BITS-1:0] p;
      case (idx)
         3'd0:    p = TABLE_BITS'(2);
         3'd1:    p = TABLE_BITS'(3);
         3'd2:    p = TABLE_BITS'(5);
         3'd3:    p = TABLE_BITS'(7);
         3'd4:    p = TABLE_BITS'(11);
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

// File: hdl/ptdt_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the prime table.
module ptdt_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ptdt_cell.sv
`timescale 1ns / 1ps
// One restoring-division step: brings in one dividend bit, settles one quotient bit.
// Depends on ptdt_pkg for the lane type.
module ptdt_cell #(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   flush,
   input  logic                   dividend_bit,
   input  ptdt_pkg::lane_type     lane_in,
   input  logic [VALUE_BITS-1:0]  quo_in,
   output ptdt_pkg::lane_type     lane_out,
   output logic [VALUE_BITS-1:0]  quo_out
);
   import ptdt_pkg::*;

   logic                  valid_ff;
   logic [TABLE_BITS-1:0] div_ff;
   logic [TABLE_BITS-1:0] rem_ff;
   logic [VALUE_BITS-1:0] quo_ff;

   logic [TABLE_BITS:0]   shifted;
   logic [TABLE_BITS:0]   diff;
   logic                  take;
   logic [TABLE_BITS-1:0] rem_in;
   logic [VALUE_BITS-1:0] quo_next;

   // Shift the next dividend bit into the partial remainder and try the subtract.
   // The remainder stays below the divisor, so the shifted value fits one extra bit.
   always_comb begin
      shifted  = {lane_in.rem, dividend_bit};
      diff     = shifted - {1'b0, lane_in.divisor};
      take     = (shifted >= {1'b0, lane_in.divisor});
      rem_in   = take ? diff[TABLE_BITS-1:0] : shifted[TABLE_BITS-1:0];
      quo_next = {quo_in[VALUE_BITS-2:0], take};
   end

   // Valid bit; a flush drops whatever the cell holds.
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane_in.valid;
      end
   end

   // Payload moves on every cycle.
   always_ff @(posedge clock) begin
      div_ff <= lane_in.divisor;
      rem_ff <= rem_in;
      quo_ff <= quo_next;
   end

   assign lane_out.valid   = valid_ff;
   assign lane_out.divisor = div_ff;
   assign lane_out.rem     = rem_ff;
   assign quo_out          = quo_ff;

endmodule

// File: hdl/ptdt_chain.sv
`timescale 1ns / 1ps
// Row of division cells: a new divisor may enter each cycle, and its quotient
// and remainder leave the last cell. Depends on ptdt_pkg, ptdt_cell.
module ptdt_chain #(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   flush,
   input  logic [VALUE_BITS-1:0]  dividend,
   input  ptdt_pkg::lane_type     lane_in,
   output ptdt_pkg::lane_type     lane_out,
   output logic [VALUE_BITS-1:0]  quo_out
);
   import ptdt_pkg::*;

   lane_type              lane [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] quo  [VALUE_BITS+1];

   assign lane[0] = lane_in;
   assign quo[0]  = '0;

   // Cell k settles quotient bit VALUE_BITS-1-k, most significant first.
   for (genvar k = 0; k < VALUE_BITS; k++) begin : g_cell
      ptdt_cell #(
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .flush        (flush),
         .dividend_bit (dividend[VALUE_BITS-1-k]),
         .lane_in      (lane[k]),
         .quo_in       (quo[k]),
         .lane_out     (lane[k+1]),
         .quo_out      (quo[k+1])
      );
   end

   assign lane_out = lane[VALUE_BITS];
   assign quo_out  = quo[VALUE_BITS];

endmodule

// File: hdl/prime_trial_division_tester_top.sv
`timescale 1ns / 1ps
// Prime trial-division tester, top level. Depends on ptdt_pkg, ptdt_ram, ptdt_chain.
//
// The block holds a table of primes that starts as 2, 3, 5, 7, 11. A request word
// with tuser = 0 appends its value to the table (dropped when the table is full)
// and gives no response. A word with tuser = 1 tests its value by trial division:
// table entries are read one per cycle, in order, and fed into a row of VALUE_BITS
// division cells. The response word turns valid in the same cycle as the next
// request word can be taken. A response word that still waits unread when the next
// test is decided holds the block in ST_DONE until it is taken. The walk stops at
// the first entry that divides the candidate or whose square exceeds it; entries of
// zero are skipped, and a candidate that outlasts the table is reported prime. One
// item is worked on at a time. A finished response waits in an output register
// while the next request word is taken. No clearing pass follows reset.
module prime_trial_division_tester_top #(
   parameter  int TABLE_DEPTH = 4096,
   parameter  int VALUE_BITS  = 32,
   localparam int DATA_W      = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // value
   input  logic              req_tuser,   // cmd
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // number
   output logic              rsp_tuser    // prime flag
);
   import ptdt_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int IFW   = $clog2(VALUE_BITS + 3);
   localparam int CMP_W = (VALUE_BITS > TABLE_BITS) ? VALUE_BITS : TABLE_BITS;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [IFW-1:0]        inflight_ff, inflight_in;
   logic                  rd_vld_ff;
   logic                  seed_sel_ff;
   logic [TABLE_BITS-1:0] seed_ff;
   logic                  verdict_ff, verdict_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [VALUE_BITS-1:0] rsp_num_ff;
   logic                  rsp_prime_ff;

   logic                  req_hs;
   logic                  wr_en;
   logic                  issue;
   logic                  flush;
   logic                  exhausted;
   logic                  term;
   logic                  term_gt;
   logic                  out_free;
   logic                  out_load;
   logic [TABLE_BITS-1:0] ram_q;
   lane_type              chain_in;
   lane_type              tail;
   logic [VALUE_BITS-1:0] tail_quo;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_hs     = req_tvalid & req_tready;
   assign wr_en      = req_hs && (req_tuser == CMD_APPEND) && (count_ff < CW'(TABLE_DEPTH));

   // Prime table; the seed primes come from a constant and are never stored.
   ptdt_ram #(
      .WIDTH (TABLE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (TABLE_BITS'(req_tdata[VALUE_BITS-1:0])),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   // Divider row fed with one table entry per cycle.
   assign chain_in.valid   = rd_vld_ff;
   assign chain_in.divisor = seed_sel_ff ? seed_ff : ram_q;
   assign chain_in.rem     = '0;

   ptdt_chain #(
      .VALUE_BITS (VALUE_BITS)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .flush    (flush),
      .dividend (cand_ff),
      .lane_in  (chain_in),
      .lane_out (tail),
      .quo_out  (tail_quo)
   );

   // Decide on the entry leaving the row: p > n / p ends the walk as prime,
   // otherwise a zero remainder ends it as composite. Zero entries are skipped.
   assign term_gt   = CMP_W'(tail.divisor) > CMP_W'(tail_quo);
   assign term      = tail.valid && (tail.divisor != '0) && (term_gt || (tail.rem == '0));
   assign issue     = (state_ff == ST_WALK) && (idx_ff < count_ff) && !term;
   assign flush     = (state_ff == ST_WALK) && term;
   assign exhausted = (state_ff == ST_WALK) && (idx_ff == count_ff) && (inflight_ff == '0);
   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign out_load  = (state_ff == ST_DONE) && out_free;

   // Controller next state.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      cand_in     = cand_ff;
      verdict_in  = verdict_ff;
      inflight_in = inflight_ff + IFW'(issue) - IFW'(tail.valid);
      case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               count_in = count_ff + CW'(1);
            end
            if (req_hs && (req_tuser == CMD_TEST)) begin
               cand_in  = req_tdata[VALUE_BITS-1:0];
               idx_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (flush) begin
               inflight_in = '0;
               verdict_in  = term_gt;
               state_in    = ST_DONE;
            end else if (exhausted) begin
               verdict_in = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: drops on take, loads when a verdict is ready.
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (out_load) begin
         rsp_vld_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= CW'(SEED_COUNT);
         idx_ff      <= '0;
         inflight_ff <= '0;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         inflight_ff <= inflight_in;
         rd_vld_ff   <= issue && !flush;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      verdict_ff  <= verdict_in;
      seed_sel_ff <= (idx_ff < CW'(SEED_COUNT));
      seed_ff     <= seed_prime(idx_ff[2:0]);
      if (out_load) begin
         rsp_num_ff   <= cand_ff;
         rsp_prime_ff <= verdict_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = DATA_W'(rsp_num_ff);
   assign rsp_tuser  = rsp_prime_ff;

   // The read stage and the cell row never hold more entries than they have slots.
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= IFW'(VALUE_BITS + 1))
      else $error("more table entries in flight than divider slots");

   // The walk never reads past the filled part of the table.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (idx_ff <= count_ff) && (count_ff >= CW'(SEED_COUNT)) && (count_ff <= CW'(TABLE_DEPTH)))
      else $error("walk index or table count out of range");

   // A decided walk leaves nothing behind in the divider.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      flush |=> !tail.valid && !rd_vld_ff && (inflight_ff == '0))
      else $error("divider not empty after flush");

   // A new request is only taken with the divider empty.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (inflight_ff == '0) && !rd_vld_ff && !tail.valid)
      else $error("divider busy while idle");

endmodule

// File: dv/prime_trial_division_tester_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for prime_trial_division_tester_top: it grows the prime table,
// tests candidates and checks every response word against a local trial-division predictor.
// Depends on ptdt_pkg and the RTL of the block.
module prime_trial_division_tester_top_tb;
   import ptdt_pkg::*;

   localparam int TABLE_DEPTH  = 256;
   localparam int VALUE_BITS   = 32;
   localparam int SIEVE_TOP    = 40000;
   localparam int CALM_TAIL    = 40;
   localparam int STALL_LIMIT  = 30000;
   localparam int DRAIN_CYCLES = 4200;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic        cmd;
      logic [31:0] value;
   } request_word_type;

   typedef struct packed {
      logic [31:0] number;
      logic        prime_flag;
   } verdict_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // value
   logic        req_tuser  = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // number
   logic        rsp_tuser;         // prime flag

   // Predictor copy of the prime table.
   logic [31:0] known_primes [TABLE_DEPTH];
   int          known_count;

   request_word_type request_words[$];
   verdict_type      pending_verdicts[$];
   request_word_type next_word;
   verdict_type      due_verdict;
   int               mismatch_count = 0;

   // Stimulus construction state.
   bit composite [SIEVE_TOP];
   int prime_list[$];
   int next_prime_idx;
   int build_count;
   int hi_idx;
   int pick;

   // Handshake pacing.
   int send_gap    = 0;
   int send_quiet  = 0;
   int recv_gap    = 0;
   int recv_quiet  = 0;
   int still_cycles = 0;

   always #5 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   prime_trial_division_tester_top #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Walk the table in order; zeros are skipped, the walk ends at the first entry
   // whose square exceeds the candidate or that divides it.
   function automatic logic trial_division_verdict(input logic [31:0] n);
      logic walking;
      logic verdict;
      int   i;
      walking = 1'b1;
      verdict = 1'b1;
      i = 0;
      while (walking && i < known_count) begin
         if (known_primes[i] != 32'd0) begin
            if (known_primes[i] > n / known_primes[i]) begin
               walking = 1'b0;
            end else if (n % known_primes[i] == 32'd0) begin
               verdict = 1'b0;
               walking = 1'b0;
            end
         end
         i++;
      end
      return verdict;
   endfunction

   // Update the table for an append word, or queue the verdict for a test word.
   function automatic void absorb_word(input request_word_type w);
      verdict_type v;
      if (w.cmd == CMD_APPEND) begin
         if (known_count < TABLE_DEPTH) begin
            known_primes[known_count] = w.value;
            known_count++;
         end
      end else begin
         v.number     = w.value;
         v.prime_flag = trial_division_verdict(w.value);
         pending_verdicts.insert(pending_verdicts.size(), v);
      end
   endfunction

   task automatic queue_append(input logic [31:0] v);
      request_words.insert(request_words.size(), request_word_type'({CMD_APPEND, v}));
      if (build_count < TABLE_DEPTH) build_count++;
   endtask

   task automatic queue_test(input logic [31:0] v);
      request_words.insert(request_words.size(), request_word_type'({CMD_TEST, v}));
   endtask

   task automatic queue_next_prime();
      queue_append(prime_list[next_prime_idx]);
      next_prime_idx++;
   endtask

   // Request driver: pops pending words and idles in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) absorb_word(request_word_type'({req_tuser, req_tdata}));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (request_words.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (request_words.size() > CALM_TAIL && send_quiet == 0 &&
                         $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 16);
               req_tvalid <= 1'b0;
            end else begin
               next_word = request_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_word.value;
               req_tuser  <= next_word.cmd;
            end
         end
         if (send_quiet > 0) send_quiet--;
         else if ($urandom_range(0, 63) == 0) send_quiet = $urandom_range(20, 300);
      end
   end

   // Response monitor: checks each word against the oldest verdict and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected response word: number %h prime flag %b",
                           rsp_tdata, rsp_tuser);
            end else begin
               due_verdict = pending_verdicts.pop_front();
               if (rsp_tdata !== due_verdict.number ||
                   rsp_tuser !== due_verdict.prime_flag) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("mismatch: number exp %h got %h, prime flag exp %b got %b",
                              due_verdict.number, rsp_tdata, due_verdict.prime_flag,
                              rsp_tuser);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (request_words.size() > CALM_TAIL && recv_quiet == 0 &&
                      $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         if (recv_quiet > 0) recv_quiet--;
         else if ($urandom_range(0, 63) == 0) recv_quiet = $urandom_range(20, 300);
      end
   end

   // Watchdog on cycles in which no word moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         still_cycles <= 0;
      end else if (still_cycles >= STALL_LIMIT) begin
         $display("prime_trial_division_tester_top regression: fail");
         $finish;
      end else begin
         still_cycles <= still_cycles + 1;
      end
   end

   initial begin
      // Small primes for well-formed appends and for building candidates.
      for (int a = 2; a < SIEVE_TOP; a++) begin
         if (!composite[a]) begin
            prime_list.insert(prime_list.size(), a);
            for (int b = a * a; b < SIEVE_TOP; b += a) composite[b] = 1'b1;
         end
      end
      for (int i = 0; i < SEED_COUNT; i++) known_primes[i] = prime_list[i];
      known_count    = SEED_COUNT;
      build_count    = SEED_COUNT;
      next_prime_idx = SEED_COUNT;

      // Directed: small candidates, squares of seed primes, extremes and a table
      // that runs out before the root of the candidate.
      queue_test(32'd0);
      queue_test(32'd1);
      queue_test(32'd2);
      queue_test(32'd3);
      queue_test(32'd4);
      queue_test(32'd9);
      queue_test(32'd25);
      queue_test(32'd49);
      queue_test(32'd121);
      queue_test(32'd143);
      queue_test(32'hFFFFFFFF);
      queue_test(32'hFFFFFFFB);
      queue_test(32'h80000000);
      queue_next_prime();
      queue_test(32'd143);
      queue_test(32'd169);
      // A zero entry is skipped by every later walk.
      queue_append(32'd0);
      queue_test(32'd289);
      queue_next_prime();
      queue_test(32'd289);
      queue_test(32'hAAAAAAAA);
      queue_test(32'h55555555);
      queue_test(32'h7FFFFFFF);

      // Random: mostly well-formed prime appends and structured candidates.
      for (int k = 0; k < 400; k++) begin
         hi_idx = next_prime_idx + 10;
         if (hi_idx > prime_list.size() - 1) hi_idx = prime_list.size() - 1;
         if ($urandom_range(0, 99) < 25) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) queue_append(32'd0);
            else if (pick == 1) queue_append($urandom_range(4, 60000));
            else queue_next_prime();
         end else begin
            case ($urandom_range(0, 5))
               0: queue_test($urandom_range(0, 2000));
               1: queue_test(prime_list[$urandom_range(0, hi_idx)] *
                             prime_list[$urandom_range(0, hi_idx)]);
               2: begin
                  pick = prime_list[$urandom_range(0, hi_idx)];
                  queue_test(pick * pick - $urandom_range(0, 1));
               end
               3: queue_test($urandom);
               4: queue_test($urandom | 32'h80000001);
               default: queue_test(prime_list[$urandom_range(0, prime_list.size() - 1)]);
            endcase
         end
      end

      // Fill the table with primes, testing now and then against the growing table.
      while (build_count < TABLE_DEPTH - 1) begin
         queue_next_prime();
         if (build_count % 32 == 0) queue_test($urandom | 32'd1);
         if (build_count % 64 == 0) queue_test(32'hFFFFFFFB);
      end
      queue_test(32'hFFFFFFFB);
      pick = prime_list[next_prime_idx - 1];
      queue_test(pick * pick);
      queue_test(pick * pick - 2);

      // One as the last entry fills the table; further appends are dropped.
      queue_append(32'd1);
      queue_append(32'hFFFFFFFF);
      queue_append($urandom);
      queue_test(32'd0);
      queue_test(32'd3);
      queue_test(32'd4);
      queue_test(32'hFFFFFFFB);
      queue_test(32'hFFFFFFFF);
      for (int k = 0; k < 6; k++) queue_test($urandom);

      // Drain: everything sent, every verdict returned, then a latency margin.
      while (request_words.size() != 0 || req_tvalid || pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("prime_trial_division_tester_top regression: pass");
      else
         $display("prime_trial_division_tester_top regression: fail");
      $finish;
   end

endmodule
